### rtl/wavosc_pkg.sv
// Shared types and constants of the wavetable oscillator with tremolo.
// Used by wavosc_isqrt and wavetable_oscillator_tremolo; depends on nothing.
`default_nettype none

package wavosc_pkg;

  // Field and register widths
  localparam int unsigned STEP_W     = 23;
  localparam int unsigned LFO_W      = 24;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned TIDX_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Default parameter values
  localparam int unsigned TABLE_DEPTH_DEF   = 100;
  localparam int unsigned LFO_SINE_BITS_DEF = 8;

  // Register reset values
  localparam logic [LFO_W-1:0]   LFO_STEP_RST = 24'd2670;
  localparam logic [DEPTH_W-1:0] DEPTH_RST    = 16'd32768;

  // Square root datapath
  localparam int unsigned RAD_W    = 40;
  localparam int unsigned ROOT_W   = 20;
  localparam int unsigned V100_W   = 23;
  localparam int unsigned SQRT_MUL = 100;

  // Tremolo datapath
  localparam int unsigned W_W     = 24;
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned Q16_W   = 17;
  localparam int unsigned DS_W    = 33;
  localparam int unsigned G_W     = 36;
  localparam int unsigned SUM_P_W = 59;

  localparam logic [Q16_W-1:0] Q16_ONE    = 17'h10000;
  localparam logic [Q16_W-1:0] POLY_INIT  = 17'd11;
  localparam logic [Q16_W-1:0] POLY_C0    = 17'd307;
  localparam logic [Q16_W-1:0] POLY_C1    = 17'd5223;
  localparam logic [Q16_W-1:0] POLY_C2    = 17'd42334;
  localparam logic [Q16_W-1:0] POLY_C3    = 17'd102944;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP     = 3'd0,
    CFG_TREMOLO_ENABLE = 3'd1,
    CFG_SPACEY_ENABLE  = 3'd2,
    CFG_LFO_STEP       = 3'd3,
    CFG_TREMOLO_DEPTH  = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOD  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_TREM = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    TS_SQ  = 4'd0,
    TS_P0  = 4'd1,
    TS_P1  = 4'd2,
    TS_P2  = 4'd3,
    TS_P3  = 4'd4,
    TS_XP  = 4'd5,
    TS_DS  = 4'd6,
    TS_G   = 4'd7,
    TS_LO  = 4'd8,
    TS_HI  = 4'd9,
    TS_SUM = 4'd10
  } trem_step_e;

endpackage

`default_nettype wire

### rtl/wavosc_isqrt.sv
// Iterative integer square root, one root bit per cycle.
// Depends on wavosc_pkg for the radicand and root widths.
`default_nettype none

module wavosc_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wavosc_pkg::RAD_W-1:0]  radicand_i,
  output logic                          done_o,
  output logic [wavosc_pkg::ROOT_W-1:0] root_o
);
  import wavosc_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAD_W-1:0]  n_q, n_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  assign rem_sh = {rem_q, n_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      n_d    = n_q << 2;
      rem_d  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d = {root_q[ROOT_W-2:0], take};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("isqrt started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("isqrt done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CNT_LAST) |=> done_q)
    else $error("isqrt missed its done pulse");

endmodule

`default_nettype wire

### rtl/wavetable_oscillator_tremolo.sv
// Wavetable oscillator with spacey square-root mode and tremolo gain.
// Depends on wavosc_pkg and wavosc_isqrt.
//
// Usage: the cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// writes registers 0..4 (phase step, tremolo enable, spacey enable, LFO step,
// tremolo depth); it is always ready. It must be written only while the
// block idles; the block itself does not enforce this.
// The input channel takes one transaction per item: mode 0 loads a table word
// and returns nothing; mode 1 produces one sample transaction on the output
// channel. The table phase is wrapped by K + 1 restoring steps, with K = 1 at
// 100 entries. Spacey mode adds the bit-serial square root; tremolo runs its
// steps on the one shared 24x17 multiplier (sine polynomial, depth product,
// two halves of the gain product).
// The table is a single-port synchronous RAM read once per sample.
// A finished sample sits in an output register: the block takes the next item
// while it waits, and holds a later result until the receiver takes the first.
// Reset clears both phases and the registers to their defaults; the table
// contents are undefined until loaded. No clearing pass is run.

`default_nettype none

module wavetable_oscillator_tremolo #(
  parameter int unsigned TableDepth  = wavosc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned LfoSineBits = wavosc_pkg::LFO_SINE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wavosc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wavosc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [wavosc_pkg::TIDX_W-1:0]      table_index_i,
  input  logic [wavosc_pkg::WORD_W-1:0]      table_value_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wavosc_pkg::WORD_W-1:0]      sample_o,
  output logic                               clipped_o
);
  import wavosc_pkg::*;

  localparam int unsigned IDX_W = $clog2(TableDepth);
  localparam int unsigned PH_W  = IDX_W + 16;
  localparam int unsigned SUM_W = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
  localparam int unsigned DIV_W = SUM_W + 1;
  localparam int unsigned MOD_K = SUM_W - PH_W;
  localparam logic [SUM_W-1:0] SPAN     = SUM_W'(TableDepth) << 16;
  localparam logic [DIV_W-1:0] SPAN_TOP = DIV_W'(SPAN) << MOD_K;
  localparam int unsigned R_W  = LfoSineBits - 2;
  localparam int unsigned X_SH = 16 - R_W;

  // Configuration registers
  logic [STEP_W-1:0]  phase_step_q;
  logic               tremolo_en_q;
  logic               spacey_en_q;
  logic [LFO_W-1:0]   lfo_step_q;
  logic [DEPTH_W-1:0] depth_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      tremolo_en_q <= 1'b0;
      spacey_en_q  <= 1'b0;
      lfo_step_q   <= LFO_STEP_RST;
      depth_q      <= DEPTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP:     phase_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_TREMOLO_ENABLE: tremolo_en_q <= cfg_data_i[0];
        CFG_SPACEY_ENABLE:  spacey_en_q  <= cfg_data_i[0];
        CFG_LFO_STEP:       lfo_step_q   <= cfg_data_i[LFO_W-1:0];
        CFG_TREMOLO_DEPTH:  depth_q      <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_e            state_q, state_d;
  trem_step_e        tstep_q, tstep_d;
  logic [PH_W-1:0]   table_phase_q, table_phase_d;
  logic [LFO_W-1:0]  lfo_phase_q, lfo_phase_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers
  logic [SUM_W-1:0]   mod_r_q, mod_r_d;
  logic [DIV_W-1:0]   mod_div_q, mod_div_d;
  logic [LFO_W-1:0]   lfo_now_q, lfo_now_d;
  logic [W_W-1:0]     w_q, w_d;
  logic [Q16_W-1:0]   x2_q, x2_d;
  logic [Q16_W-1:0]   p_q, p_d;
  logic [Q16_W-1:0]   sq_q, sq_d;
  logic [DS_W-1:0]    ds_q, ds_d;
  logic [G_W-1:0]     g_q, g_d;
  logic [PROD_W-1:0]  plo_q, plo_d;
  logic [PROD_W-1:0]  phi_q, phi_d;
  logic [WORD_W-1:0]  res_q, res_d;
  logic               clip_q, clip_d;
  logic [WORD_W-1:0]  sample_q, sample_d;
  logic               clipped_q, clipped_d;

  // Table memory
  logic [WORD_W-1:0] mem_q [TableDepth];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= table_value_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Square root unit
  logic                sq_start;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;
  logic [V100_W-1:0]   v100;
  logic [RAD_W-1:0]    radicand;

  assign v100     = V100_W'(rdata_q) * V100_W'(SQRT_MUL);
  assign radicand = {1'b0, v100, 16'b0};

  wavosc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // LFO sine argument
  logic [LfoSineBits-1:0] lfo_k;
  logic [1:0]             lfo_quad;
  logic [Q16_W-1:0]       x_raw, x_q16;

  assign lfo_k    = lfo_now_q[LFO_W-1 -: LfoSineBits];
  assign lfo_quad = lfo_k[LfoSineBits-1 -: 2];
  assign x_raw    = {1'b0, lfo_k[R_W-1:0], {X_SH{1'b0}}};
  assign x_q16    = lfo_quad[0] ? (Q16_ONE - x_raw) : x_raw;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [Q16_W-1:0]   prod_q16;

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_q16 = prod[32:16];

  // Gain and final sum
  logic [G_W-1:0]     g_base, g_twice;
  logic [SUM_P_W-1:0] total;
  logic [18:0]        res_full;

  assign g_base   = (G_W'(1) << 32) - G_W'({depth_q, 15'b0});
  assign g_twice  = G_W'({ds_q, 1'b0});
  assign total    = SUM_P_W'({phi_q, 17'b0}) + SUM_P_W'(plo_q);
  assign res_full = total[58:40];

  // Phase wrap step
  logic              mod_ge;
  logic [SUM_W-1:0]  mod_r_next;
  logic              mod_last;
  logic [PH_W-1:0]   phase_use;

  assign mod_ge     = ({1'b0, mod_r_q} >= mod_div_q);
  assign mod_r_next = mod_ge ? (mod_r_q - mod_div_q[SUM_W-1:0]) : mod_r_q;
  assign mod_last   = (mod_div_q == DIV_W'(SPAN));
  assign phase_use  = restart_i ? '0 : table_phase_q;

  logic out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign wr_addr    = IDX_W'(table_index_i);
  assign rd_addr    = phase_use[PH_W-1:16];

  always_comb begin
    state_d       = state_q;
    tstep_d       = tstep_q;
    table_phase_d = table_phase_q;
    lfo_phase_d   = lfo_phase_q;
    mod_r_d       = mod_r_q;
    mod_div_d     = mod_div_q;
    lfo_now_d     = lfo_now_q;
    w_d           = w_q;
    x2_d          = x2_q;
    p_d           = p_q;
    sq_d          = sq_q;
    ds_d          = ds_q;
    g_d           = g_q;
    plo_d         = plo_q;
    phi_d         = phi_q;
    res_d         = res_q;
    clip_d        = clip_q;
    sample_d      = sample_q;
    clipped_d     = clipped_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    sq_start      = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            mem_we = (32'(table_index_i) < TableDepth);
          end else begin
            mem_re      = 1'b1;
            lfo_now_d   = lfo_phase_q;
            lfo_phase_d = lfo_phase_q + lfo_step_q;
            mod_r_d     = SUM_W'(phase_use) + SUM_W'(phase_step_q);
            mod_div_d   = SPAN_TOP;
            state_d     = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        mod_r_d   = mod_r_next;
        mod_div_d = mod_div_q >> 1;
        if (mod_last) begin
          table_phase_d = mod_r_next[PH_W-1:0];
          if (spacey_en_q) begin
            sq_start = 1'b1;
            state_d  = ST_SQRT;
          end else begin
            w_d = {rdata_q, 8'b0};
            if (tremolo_en_q) begin
              tstep_d = TS_SQ;
              p_d     = POLY_INIT;
              state_d = ST_TREM;
            end else begin
              res_d   = rdata_q;
              clip_d  = 1'b0;
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_SQRT: begin
        if (sq_done) begin
          w_d = W_W'(sq_root);
          if (tremolo_en_q) begin
            tstep_d = TS_SQ;
            p_d     = POLY_INIT;
            state_d = ST_TREM;
          end else begin
            res_d   = WORD_W'(sq_root[ROOT_W-1:8]);
            clip_d  = 1'b0;
            state_d = ST_DONE;
          end
        end
      end

      ST_TREM: begin
        unique case (tstep_q)
          TS_SQ: begin
            mul_a   = MUL_A_W'(x_q16);
            mul_b   = x_q16;
            x2_d    = prod_q16;
            tstep_d = TS_P0;
          end
          TS_P0: begin
            mul_a   = MUL_A_W'(x2_q);
            mul_b   = p_q;
            p_d     = POLY_C0 - prod_q16;
            tstep_d = TS_P1;
          end
          TS_P1: begin
            mul_a   = MUL_A_W'(x2_q);
            mul_b   = p_q;
            p_d     = POLY_C1 - prod_q16;
            tstep_d = TS_P2;
          end
          TS_P2: begin
            mul_a   = MUL_A_W'(x2_q);
            mul_b   = p_q;
            p_d     = POLY_C2 - prod_q16;
            tstep_d = TS_P3;
          end
          TS_P3: begin
            mul_a   = MUL_A_W'(x2_q);
            mul_b   = p_q;
            p_d     = POLY_C3 - prod_q16;
            tstep_d = TS_XP;
          end
          TS_XP: begin
            mul_a   = MUL_A_W'(x_q16);
            mul_b   = p_q;
            sq_d    = (prod_q16 > Q16_ONE) ? Q16_ONE : prod_q16;
            tstep_d = TS_DS;
          end
          TS_DS: begin
            mul_a   = MUL_A_W'(depth_q);
            mul_b   = sq_q;
            ds_d    = prod[DS_W-1:0];
            tstep_d = TS_G;
          end
          TS_G: begin
            g_d     = lfo_quad[1] ? (g_base + g_twice) : (g_base - g_twice);
            tstep_d = TS_LO;
          end
          TS_LO: begin
            if (g_q[G_W-1]) begin
              res_d   = '0;
              clip_d  = |w_q;
              state_d = ST_DONE;
            end else begin
              mul_a   = w_q;
              mul_b   = g_q[16:0];
              plo_d   = prod;
              tstep_d = TS_HI;
            end
          end
          TS_HI: begin
            mul_a   = w_q;
            mul_b   = g_q[33:17];
            phi_d   = prod;
            tstep_d = TS_SUM;
          end
          TS_SUM: begin
            if (|res_full[18:16]) begin
              res_d  = '1;
              clip_d = 1'b1;
            end else begin
              res_d  = res_full[15:0];
              clip_d = 1'b0;
            end
            state_d = ST_DONE;
          end
          default: begin
            tstep_d = TS_SQ;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load  = 1'b1;
          sample_d  = res_q;
          clipped_d = clip_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tstep_q       <= TS_SQ;
      table_phase_q <= '0;
      lfo_phase_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      tstep_q       <= tstep_d;
      table_phase_q <= table_phase_d;
      lfo_phase_q   <= lfo_phase_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_r_q   <= mod_r_d;
    mod_div_q <= mod_div_d;
    lfo_now_q <= lfo_now_d;
    w_q       <= w_d;
    x2_q      <= x2_d;
    p_q       <= p_d;
    sq_q      <= sq_d;
    ds_q      <= ds_d;
    g_q       <= g_d;
    plo_q     <= plo_d;
    phi_q     <= phi_d;
    res_q     <= res_d;
    clip_q    <= clip_d;
    sample_q  <= sample_d;
    clipped_q <= clipped_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clipped_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) SUM_W'(table_phase_q) < SPAN)
    else $error("table phase beyond table span");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (sample_o == '0 || sample_o == '1))
    else $error("clipped sample is neither zero nor full scale");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output transaction raised outside the done state");

endmodule

`default_nettype wire
